// ----- design/wes_pkg.sv -----
package wes_pkg;

  localparam int GRID   = 128;
  localparam int IDX_W  = $clog2(GRID);
  localparam int ADDR_W = 2 * IDX_W;
  localparam int DEPTH  = GRID * GRID;

  localparam int SAMPLE_W = 24;
  localparam int OP_W     = 2;
  localparam int COEF_W   = 16;
  localparam logic [COEF_W-1:0] COEF_RESET = 16'd655;

  // sum of four neighbours minus four times the centre needs three extra bits; LAP_W keeps four
  localparam int LAP_W      = SAMPLE_W + 4;
  localparam int PROD_W     = COEF_W + 1 + LAP_W;
  localparam int FRAC_SHIFT = 16;
  localparam int ROUND_HALF = 1 << (FRAC_SHIFT - 1);
  localparam int TERM_W     = PROD_W - FRAC_SHIFT;
  localparam int SUM_W      = TERM_W + 2;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  // drain length, covering the stencil registers between the final read issue of the last point and its write
  localparam int DRAIN_CYCLES = 3;
  localparam int DRAIN_W      = $clog2(DRAIN_CYCLES);

  localparam logic [OP_W-1:0] OP_LOAD    = 2'd0;
  localparam logic [OP_W-1:0] OP_ADVANCE = 2'd1;
  localparam logic [OP_W-1:0] OP_READ    = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]            opcode;
    logic [IDX_W-1:0]           row;
    logic [IDX_W-1:0]           column;
    logic signed [SAMPLE_W-1:0] sample_in;
  } wes_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_out;
    logic [OP_W-1:0]            done_opcode;
  } wes_result_t;

  typedef struct packed {
    logic                       valid;
    logic [ADDR_W-1:0]          addr;
    logic signed [SAMPLE_W-1:0] data;
  } wes_write_t;

  // read issue for one grid point, first or second half of its slot
  typedef struct packed {
    logic              phase_a;
    logic              phase_b;
    logic              edge_pt;
    logic [ADDR_W-1:0] addr;
  } wes_issue_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SWEEP,
    ST_DRAIN,
    ST_FINISH
  } wes_state_t;

endpackage

// ----- design/wes_frame_ram.sv -----
module wes_frame_ram (
  input  logic                                clk,
  input  wes_pkg::wes_write_t                 wr,
  input  logic [wes_pkg::ADDR_W-1:0]          raddr0,
  input  logic [wes_pkg::ADDR_W-1:0]          raddr1,
  output logic signed [wes_pkg::SAMPLE_W-1:0] rdata0,
  output logic signed [wes_pkg::SAMPLE_W-1:0] rdata1
);
  import wes_pkg::*;

  logic signed [SAMPLE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr.valid) begin
      mem[wr.addr] <= wr.data;
    end
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

// ----- design/wes_stencil.sv -----
module wes_stencil (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [wes_pkg::COEF_W-1:0]          courant_squared,
  input  wes_pkg::wes_issue_t                 issue,
  input  logic signed [wes_pkg::SAMPLE_W-1:0] cur_rd0,
  input  logic signed [wes_pkg::SAMPLE_W-1:0] cur_rd1,
  input  logic signed [wes_pkg::SAMPLE_W-1:0] nxt_rd0,
  output wes_pkg::wes_write_t                 wr
);
  import wes_pkg::*;

  logic                       iss_a_d;
  logic                       iss_b_d;
  logic                       iss_edge_d;
  logic [ADDR_W-1:0]          iss_addr_d;

  logic signed [SAMPLE_W-1:0] right_r;
  logic signed [SAMPLE_W-1:0] up_r;
  logic signed [SAMPLE_W-1:0] prev_r;
  logic signed [SAMPLE_W-1:0] left_r;

  logic                       m_valid;
  logic                       m_edge;
  logic [ADDR_W-1:0]          m_addr;
  logic signed [LAP_W-1:0]    lap_r;
  logic signed [SAMPLE_W-1:0] m_c;
  logic signed [SAMPLE_W-1:0] m_p;

  logic                       f_valid;
  logic                       f_edge;
  logic [ADDR_W-1:0]          f_addr;
  logic signed [PROD_W-1:0]   prod_r;
  logic signed [SAMPLE_W-1:0] f_c;
  logic signed [SAMPLE_W-1:0] f_p;

  logic signed [LAP_W-1:0]    lap_next;
  logic signed [PROD_W-1:0]   prod_next;
  logic signed [PROD_W-1:0]   rnd;
  logic signed [TERM_W-1:0]   term;
  logic signed [SUM_W-1:0]    sum;
  logic signed [SAMPLE_W-1:0] sat;

  // in the second half of a slot rd0 holds the point below and rd1 the centre
  always_comb begin
    lap_next = LAP_W'(up_r) + LAP_W'(cur_rd0) + LAP_W'(left_r) + LAP_W'(right_r)
             - (LAP_W'(cur_rd1) <<< 2);
    prod_next = PROD_W'($signed({1'b0, courant_squared})) * PROD_W'(lap_r);
    rnd  = prod_r + PROD_W'(ROUND_HALF);
    term = TERM_W'(rnd >>> FRAC_SHIFT);
    sum  = SUM_W'(term) + (SUM_W'(f_c) <<< 1) - SUM_W'(f_p);
    if (sum > SUM_W'(SAMPLE_MAX)) begin
      sat = SAMPLE_MAX;
    end else if (sum < SUM_W'(SAMPLE_MIN)) begin
      sat = SAMPLE_MIN;
    end else begin
      sat = SAMPLE_W'(sum);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      iss_a_d <= 1'b0;
      iss_b_d <= 1'b0;
      m_valid <= 1'b0;
      f_valid <= 1'b0;
    end else begin
      iss_a_d <= issue.phase_a;
      iss_b_d <= issue.phase_b;
      m_valid <= iss_b_d;
      f_valid <= m_valid;
    end
  end

  always_ff @(posedge clk) begin
    iss_edge_d <= issue.edge_pt;
    iss_addr_d <= issue.addr;
    if (iss_a_d) begin
      right_r <= cur_rd0;
      up_r    <= cur_rd1;
      prev_r  <= nxt_rd0;
    end
    if (iss_b_d) begin
      lap_r  <= lap_next;
      m_c    <= cur_rd1;
      m_p    <= prev_r;
      m_addr <= iss_addr_d;
      m_edge <= iss_edge_d;
      // centre of this point is the left neighbour of the next
      left_r <= cur_rd1;
    end
    prod_r <= prod_next;
    f_c    <= m_c;
    f_p    <= m_p;
    f_addr <= m_addr;
    f_edge <= m_edge;
  end

  assign wr = '{valid: f_valid, addr: f_addr,
                data: f_edge ? '0 : sat};

endmodule

// ----- design/wave_equation_2d_step.sv -----
// from transfer to registered result: load goes through finish, read through read and finish,
// advance through sweep, drain and finish; the sweep issues the reads of each grid point in two
// halves because the current frame memory has two read ports and a point needs four reads.
// one item is in work at a time; the next transfer is taken once the block is back in idle,
// after the result is registered, and a stalled result holds the block in finish.
// synchronous reset clears control, sets frame a as current and courant_squared to 655.
module wave_equation_2d_step (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  output logic                                item_stall,
  input  wes_pkg::wes_item_t                  item,
  output logic                                result_valid,
  input  logic                                result_stall,
  output wes_pkg::wes_result_t                result,
  input  logic                                cfg_we,
  input  logic [wes_pkg::COEF_W-1:0]          cfg_data
);
  import wes_pkg::*;

  wes_state_t                 state;
  wes_state_t                 state_next;
  logic [IDX_W-1:0]           row_cnt;
  logic [IDX_W-1:0]           col_cnt;
  logic                       phase;
  logic [DRAIN_W-1:0]         drain_cnt;
  logic                       a_is_current;
  logic [COEF_W-1:0]          courant_squared;
  logic [OP_W-1:0]            pend_opcode;
  logic signed [SAMPLE_W-1:0] pend_sample;

  logic                       item_transfer;
  logic                       out_free;
  logic                       sweep_last;
  logic                       load_we;
  wes_issue_t                 issue;
  wes_write_t                 sweep_wr;
  wes_write_t                 wr_a;
  wes_write_t                 wr_b;
  logic [ADDR_W-1:0]          item_addr;
  logic [ADDR_W-1:0]          cur_addr0;
  logic [ADDR_W-1:0]          cur_addr1;
  logic [ADDR_W-1:0]          nxt_addr0;
  logic signed [SAMPLE_W-1:0] a_rd0;
  logic signed [SAMPLE_W-1:0] a_rd1;
  logic signed [SAMPLE_W-1:0] b_rd0;
  logic signed [SAMPLE_W-1:0] b_rd1;
  logic signed [SAMPLE_W-1:0] cur_rd0;
  logic signed [SAMPLE_W-1:0] cur_rd1;
  logic signed [SAMPLE_W-1:0] nxt_rd0;

  assign item_transfer = item_valid && !item_stall;
  assign out_free      = !result_valid || !result_stall;
  assign sweep_last    = phase && row_cnt == IDX_W'(GRID - 1) && col_cnt == IDX_W'(GRID - 1);
  assign item_addr     = {item.row, item.column};
  assign load_we       = item_transfer && item.opcode == OP_LOAD;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (item_transfer) begin
          case (item.opcode)
            OP_ADVANCE: state_next = ST_SWEEP;
            OP_READ:    state_next = ST_READ;
            default:    state_next = ST_FINISH;
          endcase
        end
      end
      ST_READ:   state_next = ST_FINISH;
      ST_SWEEP:  state_next = sweep_last ? ST_DRAIN : ST_SWEEP;
      ST_DRAIN:  state_next = (drain_cnt == '0) ? ST_FINISH : ST_DRAIN;
      ST_FINISH: state_next = out_free ? ST_IDLE : ST_FINISH;
      default:   state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    item_stall    = state != ST_IDLE;
    issue.phase_a = state == ST_SWEEP && !phase;
    issue.phase_b = state == ST_SWEEP && phase;
    issue.edge_pt = row_cnt == '0 || col_cnt == '0 ||
                    row_cnt == IDX_W'(GRID - 1) || col_cnt == IDX_W'(GRID - 1);
    issue.addr    = {row_cnt, col_cnt};
  end

  // first half of a slot: right neighbour and point above; second half: below and centre
  always_comb begin
    nxt_addr0 = {row_cnt, col_cnt};
    if (state == ST_IDLE) begin
      cur_addr0 = item_addr;
    end else if (phase) begin
      cur_addr0 = {row_cnt + IDX_W'(1), col_cnt};
    end else begin
      cur_addr0 = {row_cnt, col_cnt + IDX_W'(1)};
    end
    cur_addr1 = phase ? {row_cnt, col_cnt} : {row_cnt - IDX_W'(1), col_cnt};
  end

  always_comb begin
    cur_rd0 = a_is_current ? a_rd0 : b_rd0;
    cur_rd1 = a_is_current ? a_rd1 : b_rd1;
    nxt_rd0 = a_is_current ? b_rd0 : a_rd0;
    if (load_we) begin
      wr_a = '{valid: 1'b1, addr: item_addr, data: item.sample_in};
      wr_b = wr_a;
    end else begin
      wr_a = sweep_wr;
      wr_b = sweep_wr;
      wr_a.valid = sweep_wr.valid && !a_is_current;
      wr_b.valid = sweep_wr.valid && a_is_current;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      row_cnt         <= '0;
      col_cnt         <= '0;
      phase           <= 1'b0;
      drain_cnt       <= '0;
      a_is_current    <= 1'b1;
      courant_squared <= COEF_RESET;
      result_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        courant_squared <= cfg_data;
      end
      if (state == ST_IDLE && item_transfer) begin
        row_cnt <= '0;
        col_cnt <= '0;
        phase   <= 1'b0;
      end
      if (state == ST_SWEEP) begin
        phase <= !phase;
        if (phase) begin
          if (col_cnt == IDX_W'(GRID - 1)) begin
            col_cnt <= '0;
            row_cnt <= row_cnt + IDX_W'(1);
          end else begin
            col_cnt <= col_cnt + IDX_W'(1);
          end
        end
        if (sweep_last) begin
          drain_cnt <= DRAIN_W'(DRAIN_CYCLES - 1);
        end
      end
      if (state == ST_DRAIN) begin
        drain_cnt <= drain_cnt - DRAIN_W'(1);
        // the last write of the new frame lands on this same edge
        if (drain_cnt == '0) begin
          a_is_current <= !a_is_current;
        end
      end
      if (state == ST_FINISH && out_free) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && item_transfer) begin
      pend_opcode <= item.opcode;
      pend_sample <= '0;
    end
    if (state == ST_READ) begin
      pend_sample <= cur_rd0;
    end
    if (state == ST_FINISH && out_free) begin
      result <= '{sample_out: pend_sample, done_opcode: pend_opcode};
    end
  end

  wes_frame_ram u_frame_a (
    .clk    (clk),
    .wr     (wr_a),
    .raddr0 (a_is_current ? cur_addr0 : nxt_addr0),
    .raddr1 (cur_addr1),
    .rdata0 (a_rd0),
    .rdata1 (a_rd1)
  );

  wes_frame_ram u_frame_b (
    .clk    (clk),
    .wr     (wr_b),
    .raddr0 (a_is_current ? nxt_addr0 : cur_addr0),
    .raddr1 (cur_addr1),
    .rdata0 (b_rd0),
    .rdata1 (b_rd1)
  );

  wes_stencil u_stencil (
    .clk             (clk),
    .rst             (rst),
    .courant_squared (courant_squared),
    .issue           (issue),
    .cur_rd0         (cur_rd0),
    .cur_rd1         (cur_rd1),
    .nxt_rd0         (nxt_rd0),
    .wr              (sweep_wr)
  );

  a_sweep_write_window: assert property (@(posedge clk) disable iff (rst)
    sweep_wr.valid |-> (state == ST_SWEEP || state == ST_DRAIN))
    else $error("stencil write outside the frame sweep");

  a_swap_after_drain: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && !$stable(a_is_current)) |-> $past(state == ST_DRAIN))
    else $error("frame roles swapped outside the drain");

  a_load_both_frames: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && item_valid && item.opcode == OP_LOAD)
      |-> (wr_a.valid && wr_b.valid && wr_a.addr == wr_b.addr))
    else $error("load transfer did not write both frames");

  a_finish_delivers: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH && out_free) |=> (result_valid && state == ST_IDLE))
    else $error("finished item did not reach the result register");

  a_sweep_starts_clear: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SWEEP && $past(state) == ST_IDLE)
      |-> (row_cnt == '0 && col_cnt == '0 && !phase))
    else $error("sweep did not start at the first point");

endmodule

// ----- tb/wes_stencil_checker.sv -----
module wes_stencil_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       item_valid,
  input  logic                       item_stall,
  input  wes_pkg::wes_item_t         item,
  input  logic                       result_valid,
  input  logic                       result_stall,
  input  wes_pkg::wes_result_t       result,
  input  logic                       cfg_we,
  input  logic [wes_pkg::COEF_W-1:0] cfg_data,
  output int                         pending,
  output int                         mismatches
);
  import wes_pkg::*;

  localparam longint SAMPLE_HI  = 64'sd8388607;
  localparam longint SAMPLE_LO  = -64'sd8388608;
  localparam longint HALF_LSB   = 64'sd32768;
  localparam int     COEF_FRAC  = 16;
  localparam int     PRINT_CAP  = 100;

  // two frames, cur_sel picks the current one
  logic signed [SAMPLE_W-1:0] frames [2][DEPTH];
  bit                         cur_sel;
  logic [COEF_W-1:0]          courant_sq;
  wes_result_t                expected_results [$];

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatches++;
    // keep the log readable when the block is badly broken
    if (mismatches <= PRINT_CAP)
      $display("mismatch at %0t: %s, got %0d, expected %0d", $time, what, got, want);
  endtask

  function automatic logic signed [SAMPLE_W-1:0] clip_sample(input longint v);
    if (v > SAMPLE_HI) return SAMPLE_HI[SAMPLE_W-1:0];
    if (v < SAMPLE_LO) return SAMPLE_LO[SAMPLE_W-1:0];
    return v[SAMPLE_W-1:0];
  endfunction

  // five-point stencil over the whole mesh, new frame overwrites the previous one
  task automatic advance_frames();
    longint            k, c, p, lap, prod, term;
    logic [ADDR_W-1:0] at;
    bit                nx;
    k  = courant_sq;
    nx = !cur_sel;
    for (int i = 0; i < GRID; i++) begin
      for (int j = 0; j < GRID; j++) begin
        at = ADDR_W'(i * GRID + j);
        if (i == 0 || j == 0 || i == GRID - 1 || j == GRID - 1) begin
          frames[nx][at] = '0;
        end else begin
          c    = frames[cur_sel][at];
          p    = frames[nx][at];
          lap  = longint'(frames[cur_sel][at - ADDR_W'(GRID)])
               + longint'(frames[cur_sel][at + ADDR_W'(GRID)])
               + longint'(frames[cur_sel][at - ADDR_W'(1)])
               + longint'(frames[cur_sel][at + ADDR_W'(1)]) - 4 * c;
          prod = k * lap;
          // arithmetic shift of a signed value gives the floor
          term = (prod + HALF_LSB) >>> COEF_FRAC;
          frames[nx][at] = clip_sample(term + 2 * c - p);
        end
      end
    end
    cur_sel = nx;
  endtask

  // signals only move at the rising edge, so the falling edge sees what the next edge takes
  always @(negedge clk) begin
    wes_result_t       want;
    logic [ADDR_W-1:0] at;
    if (rst) begin
      expected_results.delete();
      cur_sel    = 1'b0;
      courant_sq = COEF_RESET;
    end else begin
      if (cfg_we)
        courant_sq = cfg_data;
      if (result_valid && !result_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result transfer with nothing outstanding",
                          longint'(result.sample_out), 0);
        end else begin
          want = expected_results.pop_front();
          if (result.sample_out !== want.sample_out)
            report_mismatch("sample_out", longint'(result.sample_out),
                            longint'(want.sample_out));
          if (result.done_opcode !== want.done_opcode)
            report_mismatch("done_opcode", longint'(result.done_opcode),
                            longint'(want.done_opcode));
        end
      end
      if (item_valid && !item_stall) begin
        at   = {item.row, item.column};
        want = '0;
        want.done_opcode = item.opcode;
        case (item.opcode)
          OP_LOAD: begin
            frames[1'b0][at] = item.sample_in;
            frames[1'b1][at] = item.sample_in;
          end
          OP_ADVANCE: advance_frames();
          OP_READ:    want.sample_out = frames[cur_sel][at];
          default: ;
        endcase
        expected_results.push_back(want);
      end
    end
    pending = expected_results.size();
  end

endmodule

// ----- tb/tb_wave_equation_2d_step.sv -----
module tb_wave_equation_2d_step;
  import wes_pkg::*;

  localparam int              CLK_PERIOD    = 8;
  localparam longint          LIMIT_CYCLES  = 4_000_000;
  localparam int              HOLD_CYCLES   = 300;
  localparam int              SETTLE_CYCLES = 16;
  localparam int              BLOCK_ITEMS   = 25;
  localparam int              MAX_IDLE      = 12;
  localparam logic [OP_W-1:0] OP_UNUSED     = 2'd3;

  logic              clk;
  logic              rst;
  logic              item_valid;
  logic              item_stall;
  wes_item_t         item;
  logic              result_valid;
  logic              result_stall;
  wes_result_t       result;
  logic              cfg_we;
  logic [COEF_W-1:0] cfg_data;

  int pending;
  int mismatches;
  bit idle_on      = 1'b1;
  bit held_off     = 1'b0;
  int results_seen = 0;
  int n_load       = 0;
  int n_advance    = 0;
  int n_read       = 0;
  int n_unused     = 0;
  int n_coef       = 0;

  wave_equation_2d_step u_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data)
  );

  wes_stencil_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .pending      (pending),
    .mismatches   (mismatches)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("timeout with %0d results outstanding", pending);
    $display("end of test: mismatches");
    $finish;
  end

  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    logic signed [SAMPLE_W-1:0] s;
    case ($urandom_range(0, 7))
      0: s = SAMPLE_MAX;
      1: s = SAMPLE_MIN;
      2: s = '0;
      default: begin
        s = SAMPLE_W'($urandom);
        s = s >>> $urandom_range(0, SAMPLE_W - 2);
      end
    endcase
    return s;
  endfunction

  function automatic wes_item_t make_item(input logic [OP_W-1:0] op, input int r, input int c,
                                          input logic signed [SAMPLE_W-1:0] s);
    wes_item_t it;
    it.opcode    = op;
    it.row       = r[IDX_W-1:0];
    it.column    = c[IDX_W-1:0];
    it.sample_in = s;
    return it;
  endfunction

  task automatic offer_item(input wes_item_t it);
    int gap;
    gap = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item       <= it;
    item_valid <= 1'b1;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    case (it.opcode)
      OP_LOAD:    n_load++;
      OP_ADVANCE: n_advance++;
      OP_READ:    n_read++;
      default:    n_unused++;
    endcase
  endtask

  // only while the block is idle: every transfer so far has its result back
  task automatic set_courant(input logic [COEF_W-1:0] value);
    item_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    n_coef++;
  endtask

  initial begin : receiver
    int wait_cycles;
    result_stall <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      // one long hold-off early in the directed part, the sender keeps offering
      if (!held_off && results_seen == DEPTH + 6) begin
        wait_cycles = HOLD_CYCLES;
        held_off    = 1'b1;
      end else begin
        wait_cycles = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
      end
      if (wait_cycles > 0) begin
        result_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk);
      end
      result_stall <= 1'b0;
      @(posedge clk);
      while (!result_valid) @(posedge clk);
      results_seen++;
    end
  end

  initial begin : stimulus
    logic [COEF_W-1:0] coef;
    int                roll;
    int                spare_advances;
    rst        <= 1'b1;
    item_valid <= 1'b0;
    item       <= '0;
    cfg_we     <= 1'b0;
    cfg_data   <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // every point must hold a sample before the first advance
    for (int r = 0; r < GRID; r++) begin
      for (int c = 0; c < GRID; c++) begin
        idle_on = (((r * GRID + c) / 4096) % 2) == 0;
        offer_item(make_item(OP_LOAD, r, c, rand_sample()));
      end
    end
    idle_on = 1'b1;

    // corners, extreme samples around one interior point, unused opcode,
    // then an advance at the reset coefficient and reads after it
    offer_item(make_item(OP_READ, 0, 0, '0));
    offer_item(make_item(OP_READ, GRID - 1, GRID - 1, '0));
    offer_item(make_item(OP_READ, 0, GRID - 1, '0));
    offer_item(make_item(OP_READ, GRID - 1, 0, '0));
    offer_item(make_item(OP_LOAD, 64, 64, SAMPLE_MAX));
    offer_item(make_item(OP_LOAD, 64, 65, SAMPLE_MIN));
    offer_item(make_item(OP_LOAD, 63, 64, SAMPLE_MAX));
    offer_item(make_item(OP_LOAD, 65, 64, SAMPLE_MAX));
    offer_item(make_item(OP_LOAD, 64, 63, -24'sd1));
    offer_item(make_item(OP_LOAD, 1, 1, 24'sd1));
    offer_item(make_item(OP_READ, 64, 64, '0));
    offer_item(make_item(OP_READ, 64, 65, '0));
    offer_item(make_item(OP_UNUSED, GRID - 1, GRID - 1, SAMPLE_MIN));
    offer_item(make_item(OP_READ, GRID - 1, GRID - 1, '0));
    offer_item(make_item(OP_ADVANCE, 0, 0, '0));
    offer_item(make_item(OP_READ, 0, 0, '0));
    offer_item(make_item(OP_READ, 64, 64, '0));
    offer_item(make_item(OP_READ, 64, 65, '0));
    offer_item(make_item(OP_READ, 1, 1, '0));
    offer_item(make_item(OP_READ, GRID - 2, GRID - 2, '0));
    offer_item(make_item(OP_READ, GRID - 1, 64, '0));

    // random blocks, each under its own coefficient and opening with an advance
    spare_advances = 3;
    for (int b = 0; b < 4; b++) begin
      case (b)
        0:       coef = '0;
        1:       coef = '1;
        2:       coef = COEF_W'($urandom_range(0, 65535));
        default: coef = COEF_W'($urandom_range(1, 2000));
      endcase
      set_courant(coef);
      idle_on = (b != 2);
      offer_item(make_item(OP_ADVANCE, $urandom_range(0, GRID - 1),
                           $urandom_range(0, GRID - 1), rand_sample()));
      for (int k = 1; k < BLOCK_ITEMS; k++) begin
        roll = $urandom_range(0, 99);
        if (roll < 3 && spare_advances > 0) begin
          spare_advances--;
          offer_item(make_item(OP_ADVANCE, $urandom_range(0, GRID - 1),
                               $urandom_range(0, GRID - 1), rand_sample()));
        end else if (roll < 9) begin
          offer_item(make_item(OP_UNUSED, $urandom_range(0, GRID - 1),
                               $urandom_range(0, GRID - 1), rand_sample()));
        end else if (roll < 50) begin
          offer_item(make_item(OP_LOAD, $urandom_range(0, GRID - 1),
                               $urandom_range(0, GRID - 1), rand_sample()));
        end else begin
          offer_item(make_item(OP_READ, $urandom_range(0, GRID - 1),
                               $urandom_range(0, GRID - 1), rand_sample()));
        end
      end
    end

    item_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("run covered %0d loads, %0d advances, %0d reads, %0d unused-opcode items",
             n_load, n_advance, n_read, n_unused);
    $display("%0d results back, %0d coefficient writes incl. zero and full scale, %0d-cycle hold",
             results_seen, n_coef, HOLD_CYCLES);
    if (mismatches == 0 && pending == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

// ----- files.f -----
design/wes_pkg.sv
design/wes_frame_ram.sv
design/wes_stencil.sv
design/wave_equation_2d_step.sv
tb/wes_stencil_checker.sv
tb/tb_wave_equation_2d_step.sv
